// ===== sv/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the angle-wrapping PID controller.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is asserted
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Clocked property that also holds during reset
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error(msg);

`endif

// ===== sv/awpid_pkg.sv =====
// ---------------------------------------------------------------------------
// awpid_pkg
// Types, constants and register codes of the angle-wrapping PID controller.
// ---------------------------------------------------------------------------
`default_nettype none

package awpid_pkg;

    // Angle scale: radians times 2^ANGLE_FRAC_BITS
    localparam int ANGLE_FRAC_BITS = 12;

    // pi * 2^30, rounded to nearest at the working scale below
    localparam longint unsigned PI_Q30 = 64'd3373259426;

    localparam logic signed [17:0] ANG_PI = 18'(
        (PI_Q30 + (64'd1 << (29 - ANGLE_FRAC_BITS))) >> (30 - ANGLE_FRAC_BITS));
    localparam logic signed [17:0] ANG_HALF_PI = 18'(
        (PI_Q30 + (64'd1 << (30 - ANGLE_FRAC_BITS))) >> (31 - ANGLE_FRAC_BITS));
    localparam logic signed [17:0] ANG_TWO_PI = 18'(
        (PI_Q30 + (64'd1 << (28 - ANGLE_FRAC_BITS))) >> (29 - ANGLE_FRAC_BITS));

    // Integral saturation bounds
    localparam logic signed [33:0] SUM_MAX = 34'sd2147483647;
    localparam logic signed [33:0] SUM_MIN = -34'sd2147483648;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_LIMIT = 3'd3;

    // Register reset values
    localparam logic signed [15:0] PROP_GAIN_RST   = 16'sd256;
    localparam logic signed [15:0] INTEG_GAIN_RST  = 16'sd0;
    localparam logic signed [15:0] DERIV_GAIN_RST  = 16'sd0;
    localparam logic [14:0]        DRIVE_LIMIT_RST = 15'd32767;

    typedef struct packed {
        logic signed [15:0] prop_gain;
        logic signed [15:0] integ_gain;
        logic signed [15:0] deriv_gain;
        logic [14:0]        drive_limit;
    } gains_t;

    // Operation issued to the datapath each cycle
    typedef enum logic [3:0] {
        OP_IDLE,
        OP_LOAD,
        OP_WRAP_DN,
        OP_WRAP_UP,
        OP_INTEG,
        OP_DERIV,
        OP_MUL_P,
        OP_MUL_I,
        OP_MUL_D,
        OP_ACC,
        OP_OUT
    } op_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WRAP_DN,
        ST_WRAP_UP,
        ST_DERIV,
        ST_MUL_P,
        ST_MUL_I,
        ST_MUL_D,
        ST_ACC,
        ST_OUT
    } state_t;

    // Datapath status seen by the sequencer
    typedef struct packed {
        logic above_pi;
        logic below_neg_pi;
        logic keep;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== sv/awpid_cfg.sv =====
// ---------------------------------------------------------------------------
// awpid_cfg
// Gain and limit registers, written through the configuration channel.
// ---------------------------------------------------------------------------
`default_nettype none

module awpid_cfg
    import awpid_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [15:0]          cfg_data,
    output gains_t                    gains
);

    gains_t gains_reg;
    gains_t gains_next;

    assign cfg_ready = 1'b1;
    assign gains     = gains_reg;

    // Decode the write; drop indexes beyond the list
    always_comb
    begin
        gains_next = gains_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_PROP_GAIN:   gains_next.prop_gain   = $signed(cfg_data);
                CFG_INTEG_GAIN:  gains_next.integ_gain  = $signed(cfg_data);
                CFG_DERIV_GAIN:  gains_next.deriv_gain  = $signed(cfg_data);
                CFG_DRIVE_LIMIT: gains_next.drive_limit = cfg_data[14:0];
                default:         gains_next = gains_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gains_reg.prop_gain   <= PROP_GAIN_RST;
            gains_reg.integ_gain  <= INTEG_GAIN_RST;
            gains_reg.deriv_gain  <= DERIV_GAIN_RST;
            gains_reg.drive_limit <= DRIVE_LIMIT_RST;
        end
        else
        begin
            gains_reg <= gains_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/awpid_dp.sv =====
// ---------------------------------------------------------------------------
// awpid_dp
// Datapath: one shared adder, one shared multiplier, loop state, output item.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module awpid_dp
    import awpid_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire op_t                op,
    input  wire logic signed [15:0] target_angle,
    input  wire logic signed [15:0] measured_angle,
    input  wire gains_t             gains,
    output dp_status_t              status,
    output logic signed [15:0]      drive,
    output logic                    out_valid,
    input  wire logic               out_stall
);

    // Loop state and working registers
    logic signed [16:0] err_reg;
    logic               keep_reg;
    logic signed [31:0] sum_reg;
    logic signed [16:0] last_reg;
    logic signed [17:0] deriv_reg;
    logic signed [48:0] prod_reg;
    logic signed [49:0] acc_reg;
    logic signed [15:0] drive_reg;
    logic               out_valid_reg;

    logic signed [17:0] sp_ext;
    logic signed [17:0] mv_ext;
    logic signed [17:0] diff_ext;
    logic               keep_lo;
    logic               keep_hi;
    logic signed [17:0] err_ext;

    logic signed [33:0] add_a;
    logic signed [33:0] add_b;
    logic signed [33:0] add_res;
    logic signed [31:0] sum_sat;

    logic signed [15:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [48:0] mul_res;

    logic signed [41:0] shifted;
    logic signed [41:0] lim_ext;
    logic signed [41:0] neg_lim_ext;
    logic signed [15:0] clamped;
    logic signed [15:0] lim16;
    logic signed [15:0] neg_lim16;

    // Raw difference and the two unwrapped quadrant cases
    always_comb
    begin
        sp_ext   = 18'(target_angle);
        mv_ext   = 18'(measured_angle);
        diff_ext = sp_ext - mv_ext;
        keep_lo  = (sp_ext > -ANG_HALF_PI) && (sp_ext < 18'sd0) &&
                   (mv_ext > ANG_HALF_PI) && (mv_ext < ANG_PI) &&
                   (-diff_ext > ANG_PI);
        keep_hi  = (sp_ext > ANG_HALF_PI) && (sp_ext < ANG_PI) &&
                   (mv_ext > -ANG_HALF_PI) && (mv_ext < 18'sd0) &&
                   (diff_ext > ANG_PI);
    end

    // Status back to the sequencer
    assign err_ext             = 18'(err_reg);
    assign status.above_pi     = err_ext > ANG_PI;
    assign status.below_neg_pi = err_ext < -ANG_PI;
    assign status.keep         = keep_reg;
    assign status.out_free     = !out_valid_reg || !out_stall;

    // Shared adder operand select
    always_comb
    begin
        add_a = '0;
        add_b = '0;
        case (op)
            OP_WRAP_DN:
            begin
                add_a = 34'(err_reg);
                add_b = -34'(ANG_TWO_PI);
            end
            OP_WRAP_UP:
            begin
                add_a = 34'(err_reg);
                add_b = 34'(ANG_TWO_PI);
            end
            OP_INTEG:
            begin
                add_a = 34'(sum_reg);
                add_b = 34'(err_reg);
            end
            OP_DERIV:
            begin
                add_a = 34'(err_reg);
                add_b = -34'(last_reg);
            end
            default:
            begin
                add_a = '0;
                add_b = '0;
            end
        endcase
        add_res = add_a + add_b;
    end

    // Saturate the integral to the signed 32-bit range
    always_comb
    begin
        if (add_res > SUM_MAX)
        begin
            sum_sat = SUM_MAX[31:0];
        end
        else if (add_res < SUM_MIN)
        begin
            sum_sat = SUM_MIN[31:0];
        end
        else
        begin
            sum_sat = add_res[31:0];
        end
    end

    // Shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (op)
            OP_MUL_P:
            begin
                mul_a = gains.prop_gain;
                mul_b = 33'(err_reg);
            end
            OP_MUL_I:
            begin
                mul_a = gains.integ_gain;
                mul_b = 33'(sum_reg);
            end
            OP_MUL_D:
            begin
                mul_a = gains.deriv_gain;
                mul_b = 33'(deriv_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_res = mul_a * mul_b;
    end

    // Floor shift by 8 and clamp to the drive limit
    always_comb
    begin
        shifted     = $signed(acc_reg[49:8]);
        lim_ext     = $signed({27'd0, gains.drive_limit});
        neg_lim_ext = -lim_ext;
        lim16       = $signed({1'b0, gains.drive_limit});
        neg_lim16   = -lim16;
        if (shifted > lim_ext)
        begin
            clamped = lim16;
        end
        else if (shifted < neg_lim_ext)
        begin
            clamped = neg_lim16;
        end
        else
        begin
            clamped = shifted[15:0];
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        case (op)
            OP_LOAD:
            begin
                err_reg  <= diff_ext[16:0];
                keep_reg <= keep_lo || keep_hi;
            end
            OP_WRAP_DN, OP_WRAP_UP:
            begin
                err_reg <= add_res[16:0];
            end
            OP_DERIV:
            begin
                deriv_reg <= add_res[17:0];
            end
            OP_MUL_P:
            begin
                prod_reg <= mul_res;
            end
            OP_MUL_I:
            begin
                prod_reg <= mul_res;
                acc_reg  <= 50'(prod_reg);
            end
            OP_MUL_D:
            begin
                prod_reg <= mul_res;
                acc_reg  <= acc_reg + 50'(prod_reg);
            end
            OP_ACC:
            begin
                acc_reg <= acc_reg + 50'(prod_reg);
            end
            OP_OUT:
            begin
                drive_reg <= clamped;
            end
            default:
            begin
                err_reg <= err_reg;
            end
        endcase
    end

    // Integral and previous error, cleared by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg  <= '0;
            last_reg <= '0;
        end
        else if (op == OP_INTEG)
        begin
            sum_reg <= sum_sat;
        end
        else if (op == OP_DERIV)
        begin
            last_reg <= err_reg;
        end
    end

    // Output item valid: set when the drive register is loaded, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (op == OP_OUT)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign drive     = drive_reg;
    assign out_valid = out_valid_reg;

    `ASSERT_CLK(a_err_wrapped, (op == OP_INTEG && !keep_reg) |-> (err_ext <= ANG_PI && err_ext >= -ANG_PI), "wrapped error outside minus pi to pi")
    `ASSERT_CLK(a_drive_in_limit, (op == OP_OUT) |=> (drive_reg <= $past(lim16) && drive_reg >= $past(neg_lim16)), "drive outside the limit")

endmodule

`default_nettype wire

// ===== sv/awpid_seq.sv =====
// ---------------------------------------------------------------------------
// awpid_seq
// Sequencer: steps one item through wrap, integrate, derivative, multiply, accumulate and output phases.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module awpid_seq
    import awpid_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire dp_status_t status,
    output op_t             op
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and datapath operation
    always_comb
    begin
        state_next = state_reg;
        op         = OP_IDLE;
        in_stall   = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    op         = OP_LOAD;
                    state_next = ST_WRAP_DN;
                end
            end
            ST_WRAP_DN:
            begin
                if (status.keep)
                begin
                    op         = OP_INTEG;
                    state_next = ST_DERIV;
                end
                else if (status.above_pi)
                begin
                    op = OP_WRAP_DN;
                end
                else if (status.below_neg_pi)
                begin
                    op         = OP_WRAP_UP;
                    state_next = ST_WRAP_UP;
                end
                else
                begin
                    op         = OP_INTEG;
                    state_next = ST_DERIV;
                end
            end
            ST_WRAP_UP:
            begin
                if (status.below_neg_pi)
                begin
                    op = OP_WRAP_UP;
                end
                else
                begin
                    op         = OP_INTEG;
                    state_next = ST_DERIV;
                end
            end
            ST_DERIV:
            begin
                op         = OP_DERIV;
                state_next = ST_MUL_P;
            end
            ST_MUL_P:
            begin
                op         = OP_MUL_P;
                state_next = ST_MUL_I;
            end
            ST_MUL_I:
            begin
                op         = OP_MUL_I;
                state_next = ST_MUL_D;
            end
            ST_MUL_D:
            begin
                op         = OP_MUL_D;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                op         = OP_ACC;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                // Hold until the output register can take the item
                if (status.out_free)
                begin
                    op         = OP_OUT;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `ASSERT_CLK(a_busy_after_take, (in_valid && !in_stall) |=> in_stall, "input taken while an item is in work")
    `ASSERT_CLK(a_out_only_when_free, (op == OP_OUT) |-> status.out_free, "output loaded over an untaken item")

endmodule

`default_nettype wire

// ===== sv/angle_wrapping_pid_controller_core.sv =====
// ---------------------------------------------------------------------------
// angle_wrapping_pid_controller_core
// PID controller on angle error wrapped into minus pi to pi.
// ---------------------------------------------------------------------------
// Input channel: target_angle and measured_angle (radians x 4096) with
// in_valid/in_stall; an item is taken when in_valid is high and in_stall low.
// Output channel: drive with out_valid/out_stall, one item per input item.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; index 0..3
// selects prop, integ, deriv gain and drive limit; other indexes are dropped.
// cfg_ready is always high; write only while no item is in work.
// The error is wrapped by 2*pi correction steps as needed (none when the raw
// difference is already within minus pi to pi or kept). One shared adder runs
// the wrap, integrate and derivative steps, then one shared 16x33 multiplier
// forms the three gain products in turn. in_stall is high while an item is in
// work, so a new item is taken only after the last one is done. The result
// sits in an output register, so a stalled receiver does not block the next
// item until that item is ready to leave.
// Reset clears the integral, previous error, valid flag and restores gains.
// ---------------------------------------------------------------------------
`default_nettype none

module angle_wrapping_pid_controller_core
    import awpid_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic signed [15:0]   target_angle,
    input  wire logic signed [15:0]   measured_angle,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic signed [15:0]        drive,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [15:0]          cfg_data
);

    gains_t     gains;
    dp_status_t status;
    op_t        op;

    awpid_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .gains     (gains)
    );

    awpid_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .op       (op)
    );

    awpid_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .op             (op),
        .target_angle   (target_angle),
        .measured_angle (measured_angle),
        .gains          (gains),
        .status         (status),
        .drive          (drive),
        .out_valid      (out_valid),
        .out_stall      (out_stall)
    );

endmodule

`default_nettype wire

// ===== tb/awpid_drive_checker.sv =====
// ---------------------------------------------------------------------------
// awpid_drive_checker
// Watches the ports of the angle-wrapping PID controller, keeps its own copy
// of the gains, integral and previous error, predicts each drive item from
// the angles accepted and compares it with the drive item that leaves.
// ---------------------------------------------------------------------------

module awpid_drive_checker
    import awpid_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  logic signed [15:0]   target_angle,
    input  logic signed [15:0]   measured_angle,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  logic signed [15:0]   drive,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_data,
    output int                   fail_count,
    output int                   outstanding,
    output int                   checked
);

    // Shadow copy of the gain registers
    logic signed [15:0] kp = PROP_GAIN_RST;
    logic signed [15:0] ki = INTEG_GAIN_RST;
    logic signed [15:0] kd = DERIV_GAIN_RST;
    logic [14:0]        limit = DRIVE_LIMIT_RST;

    // Shadow copy of the controller state
    logic signed [31:0] integ_sum = '0;
    logic signed [16:0] prev_err  = '0;

    // Drive values still owed by the block, oldest first
    logic signed [15:0] drive_due[$];

    int errors   = 0;
    int n_due    = 0;
    int n_passed = 0;

    assign fail_count  = errors;
    assign outstanding = n_due;
    assign checked     = n_passed;

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= 20)
            $display("%0t checker: %s", $time, msg);
    endtask

    // Wrap the angle error, integrate, differentiate and form the clamped drive
    function automatic logic signed [15:0] next_drive(input logic signed [15:0] sp,
                                                      input logic signed [15:0] mv);
        longint pi_l, half_l, two_l;
        longint s, m, e, sum, de, acc, res, lim;
        logic keep_lo, keep_hi;
        pi_l   = longint'(ANG_PI);
        half_l = longint'(ANG_HALF_PI);
        two_l  = longint'(ANG_TWO_PI);
        s = sp;
        m = mv;
        // Keep the raw difference in the two crossed quadrants
        keep_lo = (-half_l < s) && (s < 0) && (half_l < m) && (m < pi_l) && (m - s > pi_l);
        keep_hi = (half_l < s) && (s < pi_l) && (-half_l < m) && (m < 0) && (s - m > pi_l);
        e = s - m;
        if (!(keep_lo || keep_hi)) begin
            while (e > pi_l)
                e -= two_l;
            while (e < -pi_l)
                e += two_l;
        end
        // Saturate the integral at the 32-bit range
        sum = longint'(integ_sum) + e;
        if (sum > longint'(SUM_MAX))
            sum = longint'(SUM_MAX);
        if (sum < longint'(SUM_MIN))
            sum = longint'(SUM_MIN);
        integ_sum = 32'(sum);
        de = e - longint'(prev_err);
        prev_err = 17'(e);
        acc = longint'(kp) * e + longint'(ki) * sum + longint'(kd) * de;
        res = acc >>> 8;
        lim = longint'(limit);
        if (res > lim)
            res = lim;
        else if (res < -lim)
            res = -lim;
        return 16'(res);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic signed [15:0] want;
        if (!rst_n)
        begin
            kp = PROP_GAIN_RST;
            ki = INTEG_GAIN_RST;
            kd = DERIV_GAIN_RST;
            limit = DRIVE_LIMIT_RST;
            integ_sum = '0;
            prev_err = '0;
            drive_due.delete();
            n_due = 0;
        end
        else
        begin
            // Track register writes; drop unused indexes
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_PROP_GAIN:   kp = cfg_data;
                    CFG_INTEG_GAIN:  ki = cfg_data;
                    CFG_DERIV_GAIN:  kd = cfg_data;
                    CFG_DRIVE_LIMIT: limit = cfg_data[14:0];
                    default: ;
                endcase
            end
            // Compare a leaving drive item with the oldest prediction
            if (out_valid && !out_stall)
            begin
                if (drive_due.size() == 0)
                    report_mismatch($sformatf("drive item %0d with no item outstanding",
                                              drive));
                else
                begin
                    want = drive_due.pop_front();
                    n_passed++;
                    if (drive !== want)
                        report_mismatch($sformatf("drive %0d, expected %0d", drive, want));
                end
            end
            // Predict the drive for an accepted angle pair
            if (in_valid && !in_stall)
                drive_due.push_back(next_drive(target_angle, measured_angle));
            n_due = drive_due.size();
        end
    end

endmodule

// ===== tb/tb_angle_wrapping_pid_controller_core.sv =====
// ---------------------------------------------------------------------------
// tb_angle_wrapping_pid_controller_core
// Drives angle pairs and gain settings into the PID controller core.
// A directed part covers the wrap boundaries, the crossed quadrants, the
// floor shift and the clamp; random phases with bursty input, a patterned
// receiver and varied gains follow, and a run of the largest kept error
// builds up a large integral. The checker beside the block predicts and compares.
// ---------------------------------------------------------------------------

module tb_angle_wrapping_pid_controller_core;
    import awpid_pkg::*;

    localparam int CYCLE_LIMIT     = 400_000;
    localparam int SETTLE_CYCLES   = 16;
    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 235;
    localparam int FILL_ITEMS      = 40;
    localparam int HOLD_CYCLES     = 150;
    localparam int CFG_FIRST_UNUSED = int'(CFG_DRIVE_LIMIT) + 1;
    localparam int CFG_LAST_INDEX   = (1 << CFG_IDX_W) - 1;

    typedef enum int { RX_FREE, RX_PATTERN } rx_mode_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic signed [15:0]   target_angle;
    logic signed [15:0]   measured_angle;
    logic                 out_valid;
    logic                 out_stall;
    logic signed [15:0]   drive;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [15:0]          cfg_data;

    int fail_count;
    int outstanding;
    int checked;

    // Sender and receiver control
    rx_mode_t rx_mode;
    int       hold_request;
    logic     idle_on;
    int       burst_left;
    int       sent;
    int       settings;

    angle_wrapping_pid_controller_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .target_angle   (target_angle),
        .measured_angle (measured_angle),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .drive          (drive),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    awpid_drive_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .target_angle   (target_angle),
        .measured_angle (measured_angle),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .drive          (drive),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .fail_count     (fail_count),
        .outstanding    (outstanding),
        .checked        (checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Abort a run that hangs
    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d items still owed", cycles, outstanding);
        $display("RESULT: ERROR");
        $finish;
    end

    // Receiver: long hold on request, else free or alternating stall runs
    initial
    begin : receiver
        int   run_left;
        int   hold_left;
        logic stalling;
        run_left = 0;
        hold_left = 0;
        stalling = 1'b0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (rx_mode == RX_FREE)
                out_stall <= 1'b0;
            else
            begin
                if (run_left == 0)
                begin
                    stalling = !stalling;
                    run_left = stalling ? $urandom_range(1, 6) : $urandom_range(1, 10);
                end
                run_left--;
                out_stall <= stalling;
            end
        end
    end

    // Offer one item and hold it until taken; then maybe leave a gap
    task automatic offer_item(input logic signed [15:0] t, input logic signed [15:0] m);
        in_valid <= 1'b1;
        target_angle <= t;
        measured_angle <= m;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
        sent++;
        if (idle_on)
        begin
            if (burst_left > 0)
                burst_left--;
            else
            begin
                in_valid <= 1'b0;
                target_angle <= 16'($urandom);
                measured_angle <= 16'($urandom);
                repeat ($urandom_range(1, 12)) @(negedge clk);
                burst_left = $urandom_range(0, 20);
            end
        end
    endtask

    // Stop offering and wait until every drive item has left
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
    endtask

    // Write all four registers and one unused index
    task automatic load_gains(input logic [15:0] p, input logic [15:0] i,
                              input logic [15:0] d, input logic [15:0] l);
        write_reg(CFG_PROP_GAIN, p);
        write_reg(CFG_INTEG_GAIN, i);
        write_reg(CFG_DERIV_GAIN, d);
        write_reg(CFG_DRIVE_LIMIT, l);
        write_reg(CFG_IDX_W'($urandom_range(CFG_FIRST_UNUSED, CFG_LAST_INDEX)),
                  16'($urandom));
        cfg_valid <= 1'b0;
        settings++;
    endtask

    // Change receiver behaviour away from its sampling edge
    task automatic set_receiver(input rx_mode_t mode, input int hold);
        @(posedge clk);
        rx_mode = mode;
        hold_request = hold;
        @(negedge clk);
    endtask

    function automatic logic [15:0] pick_gain();
        case ($urandom_range(0, 3))
            0:       return 16'($urandom);
            1:       return 16'($urandom_range(0, 1024) - 512);
            default: return 16'($urandom_range(0, 128) - 64);
        endcase
    endfunction

    function automatic logic [15:0] pick_limit();
        if ($urandom_range(0, 1))
            return 16'($urandom);
        return 16'($urandom_range(0, 2000));
    endfunction

    // Angle on or next to zero, half pi, pi, two pi or the 16-bit ends
    function automatic logic signed [15:0] boundary_angle();
        int hp, pi_i, v;
        hp = int'(ANG_HALF_PI);
        pi_i = int'(ANG_PI);
        case ($urandom_range(0, 6))
            0:       v = 0;
            1:       v = hp;
            2:       v = pi_i;
            3:       v = 2 * pi_i;
            4:       v = 32767;
            default: v = int'($urandom_range(0, 3));
        endcase
        v = v + int'($urandom_range(0, 2)) - 1;
        if ($urandom_range(0, 1))
            v = -v;
        return 16'(v);
    endfunction

    task automatic offer_random_item();
        int hp, pi_i, kind;
        logic signed [15:0] t, m;
        hp = int'(ANG_HALF_PI);
        pi_i = int'(ANG_PI);
        kind = $urandom_range(0, 99);
        if (kind < 40)
        begin
            // Both angles within minus pi to pi
            t = 16'(int'($urandom_range(0, 2 * pi_i)) - pi_i);
            m = 16'(int'($urandom_range(0, 2 * pi_i)) - pi_i);
        end
        else if (kind < 60)
        begin
            // Around the crossed quadrants
            t = 16'(-int'($urandom_range(0, hp + 1)));
            m = 16'(int'($urandom_range(hp, pi_i)));
            if ($urandom_range(0, 1))
            begin
                t = -t;
                m = -m;
                {t, m} = {m, t};
            end
        end
        else if (kind < 75)
        begin
            t = boundary_angle();
            m = boundary_angle();
        end
        else
        begin
            t = 16'($urandom);
            m = 16'($urandom);
        end
        offer_item(t, m);
    endtask

    initial
    begin : stimulus
        rst_n = 1'b0;
        in_valid = 1'b0;
        target_angle = '0;
        measured_angle = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        rx_mode = RX_PATTERN;
        hold_request = 0;
        idle_on = 1'b1;
        burst_left = 0;
        sent = 0;
        settings = 0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        repeat (3) @(negedge clk);

        // Reset gains give drive equal to the wrapped error
        offer_item(16'sd0, 16'sd0);
        offer_item(16'sd32767, -16'sd32768);
        offer_item(-16'sd32768, 16'sd32767);
        offer_item(16'(ANG_PI), 16'sd0);
        offer_item(16'(-ANG_PI), 16'sd0);
        offer_item(16'(ANG_PI + 1), 16'sd0);
        offer_item(16'(-ANG_PI - 1), 16'sd0);
        // Crossed quadrants: raw difference kept only with strict margins
        offer_item(-16'sd2, 16'(ANG_PI - 1));
        offer_item(-16'sd1, 16'(ANG_PI - 1));
        offer_item(16'(-ANG_HALF_PI), 16'(ANG_PI - 1));
        offer_item(16'(-ANG_HALF_PI + 1), 16'(ANG_PI - 1));
        offer_item(-16'sd100, 16'(ANG_PI));
        offer_item(16'(ANG_PI - 1), 16'(-ANG_HALF_PI + 1));
        offer_item(16'(ANG_PI - 1), 16'(-ANG_HALF_PI));
        offer_item(16'(ANG_HALF_PI + 2), 16'(-ANG_HALF_PI + 1));
        wait_idle();

        // Smallest gain: the shift floors towards minus infinity
        load_gains(16'sd1, 16'sd0, 16'sd0, 16'h7FFF);
        offer_item(16'sd1, 16'sd0);
        offer_item(-16'sd1, 16'sd0);
        offer_item(-16'sd256, 16'sd0);
        offer_item(-16'sd257, 16'sd0);
        wait_idle();

        // Clamp to a small limit on both sides
        load_gains(16'h7FFF, 16'sd0, 16'h8000, 16'd100);
        offer_item(16'sd1000, 16'sd0);
        offer_item(-16'sd1000, 16'sd0);
        wait_idle();

        // Top bit of the limit is dropped, leaving a zero limit
        load_gains(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000);
        offer_item(16'sd3000, -16'sd3000);
        offer_item(-16'sd5000, 16'sd4000);
        wait_idle();

        // Random phases over a spread of gain settings
        for (int k = 0; k < RANDOM_PHASES; k++)
        begin
            case (k)
                0:       load_gains(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF);
                1:       load_gains(16'h8000, 16'h8000, 16'h8000, 16'h7FFF);
                2:       load_gains(pick_gain(), pick_gain(), pick_gain(), 16'd1);
                default: load_gains(pick_gain(), pick_gain(), pick_gain(), pick_limit());
            endcase
            idle_on = (k != 0) && (k % 3 != 2);
            burst_left = 0;
            // First phase: hold the receiver off so the block backs up
            if (k == 0)
                set_receiver(RX_PATTERN, HOLD_CYCLES);
            else
                set_receiver((k % 4 == 3) ? RX_FREE : RX_PATTERN, 0);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (k == 4 && n == ITEMS_PER_PHASE / 2)
                    wait_idle();
                offer_random_item();
            end
            wait_idle();
        end

        // Run of the largest kept error back to back builds up a large integral
        load_gains(16'sd256, 16'sd1, 16'sd0, 16'h7FFF);
        idle_on = 1'b0;
        set_receiver(RX_FREE, 0);
        for (int n = 0; n < FILL_ITEMS; n++)
            offer_item(16'(ANG_PI - 1), 16'(-ANG_HALF_PI + 1));
        idle_on = 1'b1;
        set_receiver(RX_PATTERN, 0);
        repeat (8) offer_random_item();
        wait_idle();

        $display("Covered %0d angle pairs under %0d gain settings, %0d drive items compared,",
                 sent, settings, checked);
        $display("including wrap edges, crossed quadrants, clamping and a growing integral.");
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
